// ----- hw/rtl/sce_pkg.sv -----
// ----------------------------------------------------------------------------
// sce_pkg: shared types and constants of the sensor change event encoder
// Word formats of both channels, the stored per-module entry and the
// layout of the change mask that the scan unit walks through.
// ----------------------------------------------------------------------------
package sce_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int GROUPS        = 4;
    localparam int MASK_W        = GROUPS * BITS_PER_BYTE;
    localparam int POS_W         = $clog2(MASK_W);
    localparam int BIT_W         = $clog2(BITS_PER_BYTE);
    localparam int MOD_W         = 3;
    localparam int SENSOR_W      = 5;
    // wide enough to compare an index against any module count
    localparam int CMP_W         = 6;

    typedef struct packed {
        logic [MOD_W-1:0]         module_index;
        logic [BITS_PER_BYTE-1:0] byte_a;
        logic [BITS_PER_BYTE-1:0] byte_b;
    } t_in_word;

    typedef struct packed {
        logic [MOD_W-1:0]    event_module;
        logic [SENSOR_W-1:0] sensor_number;
        logic                released;
        logic                last_of_run;
    } t_out_word;

    // one module's stored reading
    typedef struct packed {
        logic                     primed;
        logic [BITS_PER_BYTE-1:0] prev_a;
        logic [BITS_PER_BYTE-1:0] prev_b;
    } t_entry;

    // result of the lowest-set-bit search
    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] pos;
    } t_find;

endpackage

// ----- hw/rtl/sensor_change_event_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// sensor_change_event_encoder_unit: sensor change event encoder
// Turns sensor module readings into one event word per changed sensor bit.
// ----------------------------------------------------------------------------
// Each input word carries a module index and the two sensor bytes of that
// module. The unit compares them with the bytes it stored for the module and
// sends one output word per changed bit: first bits newly set in byte A, then
// in byte B, then bits cleared in A, then in B, lowest bit first in each
// group. sensor_number is 8 minus the bit position, plus 8 for byte B.
// The first reading of a module only stores its bytes; a reading with an
// index of MODULES or more is dropped. The change mask is built in the cycle
// the word is taken, then one shared lowest-set-bit unit picks out one event
// per cycle while the output register is free to take it; a reading with no
// event leaves the unit ready for the next reading. Input ready is low while
// events are being sent, but a finished event may sit in the output register
// while the next reading is taken.
// ----------------------------------------------------------------------------
module sensor_change_event_encoder_unit #(
    parameter int MODULES = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  sce_pkg::t_in_word     i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output sce_pkg::t_out_word    o_out_word
);
    import sce_pkg::*;

    localparam int IDX_W = (MODULES > 1) ? $clog2(MODULES) : 1;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    // sequencer and output register
    t_state           r_state,     n_state;
    logic [MASK_W-1:0] r_mask,     n_mask;
    logic [MOD_W-1:0] r_module,    n_module;
    logic             r_out_valid, n_out_valid;
    t_out_word        r_out_word,  n_out_word;

    logic             accept;
    logic             in_range;
    logic [CMP_W-1:0] idx_ext;
    logic [IDX_W-1:0] idx;
    t_entry           rd_entry;
    logic [MASK_W-1:0] new_mask;
    t_find            find;
    logic             slot_free;
    logic             emit;
    logic [MASK_W-1:0] rest_mask;
    logic [BIT_W-1:0] bit_pos;
    logic             high_half;

    // ---- input side ----
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign idx_ext    = CMP_W'(i_in_word.module_index);
    assign in_range   = idx_ext < CMP_W'(MODULES);
    assign idx        = idx_ext[IDX_W-1:0];

    sce_store #(
        .MODULES (MODULES)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_idx   (idx),
        .o_rd_entry (rd_entry),
        .i_wr_en    (accept && in_range),
        .i_wr_idx   (idx),
        .i_wr_a     (i_in_word.byte_a),
        .i_wr_b     (i_in_word.byte_b)
    );

    // group order from the low end: set in A, set in B, cleared in A, cleared in B
    assign new_mask = {rd_entry.prev_b & ~i_in_word.byte_b,
                       rd_entry.prev_a & ~i_in_word.byte_a,
                       i_in_word.byte_b & ~rd_entry.prev_b,
                       i_in_word.byte_a & ~rd_entry.prev_a};

    // ---- shared search unit ----
    sce_find u_find (
        .i_mask (r_mask),
        .o_find (find)
    );

    // an event may be loaded when the output register is empty or draining
    assign slot_free = !r_out_valid || i_out_ready;
    assign emit      = (r_state == S_SCAN) && slot_free;
    assign rest_mask = r_mask & ~(MASK_W'(1) << find.pos);
    assign bit_pos   = find.pos[BIT_W-1:0];
    assign high_half = find.pos[BIT_W];

    always_comb begin
        n_state     = r_state;
        n_mask      = r_mask;
        n_module    = r_module;
        n_out_word  = r_out_word;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                // unprimed module: bytes only stored, no events
                if (accept && in_range && rd_entry.primed && (new_mask != '0)) begin
                    n_state  = S_SCAN;
                    n_mask   = new_mask;
                    n_module = i_in_word.module_index;
                end
            end
            S_SCAN: begin
                if (emit) begin
                    n_mask                   = rest_mask;
                    n_out_valid              = 1'b1;
                    n_out_word.event_module  = r_module;
                    n_out_word.sensor_number = SENSOR_W'(BITS_PER_BYTE)
                                             - SENSOR_W'(bit_pos)
                                             + (high_half ? SENSOR_W'(BITS_PER_BYTE)
                                                          : SENSOR_W'(0));
                    n_out_word.released      = find.pos[POS_W-1];
                    n_out_word.last_of_run   = (rest_mask == '0);
                    if (rest_mask == '0) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_mask     <= n_mask;
        r_module   <= n_module;
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef ASSERT_OFF
    // a scan never runs on an empty mask
    a_scan_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_mask != '0))
        else $error("scan with empty change mask");

    // every emitted event retires exactly one mask bit
    a_one_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> ($countones(r_mask) == $countones($past(r_mask)) - 1))
        else $error("event did not retire one change bit");

    // the last event of a reading frees the input side
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && (rest_mask == '0)) |=> o_in_ready)
        else $error("input not ready after last event");

    // sensor numbers stay within 1..16
    a_sensor_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_word.sensor_number >= SENSOR_W'(1)) &&
                         (o_out_word.sensor_number <= SENSOR_W'(2 * BITS_PER_BYTE))))
        else $error("sensor number out of range");

    // events only name modules that exist
    a_module_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (CMP_W'(o_out_word.event_module) < CMP_W'(MODULES)))
        else $error("event for unknown module");
`endif

endmodule

// ----- hw/rtl/sce_store.sv -----
// ----------------------------------------------------------------------------
// sce_store: per-module store of the previous sensor bytes
// One entry per module, with a read index and a separate write index; the primed flags
// are cleared by reset, the bytes are only meaningful once primed.
// ----------------------------------------------------------------------------
module sce_store #(
    parameter int  MODULES = 5,
    localparam int IDX_W   = (MODULES > 1) ? $clog2(MODULES) : 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [IDX_W-1:0]                    i_rd_idx,
    output sce_pkg::t_entry                     o_rd_entry,
    input  logic                                i_wr_en,
    input  logic [IDX_W-1:0]                    i_wr_idx,
    input  logic [sce_pkg::BITS_PER_BYTE-1:0]   i_wr_a,
    input  logic [sce_pkg::BITS_PER_BYTE-1:0]   i_wr_b
);
    import sce_pkg::*;

    logic [MODULES-1:0]       r_primed;
    logic [BITS_PER_BYTE-1:0] r_prev_a [MODULES];
    logic [BITS_PER_BYTE-1:0] r_prev_b [MODULES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= '0;
        end else if (i_wr_en) begin
            r_primed[i_wr_idx] <= 1'b1;
        end
    end

    // bytes need no reset: an unprimed entry is never compared
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_prev_a[i_wr_idx] <= i_wr_a;
            r_prev_b[i_wr_idx] <= i_wr_b;
        end
    end

    always_comb begin
        o_rd_entry.primed = r_primed[i_rd_idx];
        o_rd_entry.prev_a = r_prev_a[i_rd_idx];
        o_rd_entry.prev_b = r_prev_b[i_rd_idx];
    end

endmodule

// ----- hw/rtl/sce_find.sv -----
// ----------------------------------------------------------------------------
// sce_find: lowest set bit search over the change mask
// Priority encoder shared by every event of a reading.
// ----------------------------------------------------------------------------
module sce_find (
    input  logic [sce_pkg::MASK_W-1:0] i_mask,
    output sce_pkg::t_find             o_find
);
    import sce_pkg::*;

    always_comb begin
        o_find.hit = |i_mask;
        o_find.pos = '0;
        // walk downwards so the lowest set bit wins
        for (int i = MASK_W - 1; i >= 0; i--) begin
            if (i_mask[i]) begin
                o_find.pos = POS_W'(i);
            end
        end
    end

endmodule
